// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file dskv_checker.sv
// expect signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dskv_pkg.sv =====
// types and constants of the decaying sine kick voice
// used by the multiplier, the register file and the top level
package dskv_pkg;

  localparam int AW = 28;
  localparam int BW = 24;
  localparam int PW = AW + 1 + BW;
  localparam int ADDR_W = 4;
  localparam int CFG_W = 32;

  localparam logic signed [23:0] OSC_COEF_RST = 24'sd8388428;
  localparam logic [22:0] START_SINE_RST = 23'd27452;
  localparam logic [23:0] DECAY_COEF_RST = 24'd8385114;
  localparam int MAX_LEN_RST = 48000;

  localparam logic [23:0] ENV_ONE = 24'h800000;
  localparam logic [23:0] ENV_MAX = 24'hffffff;
  localparam logic [23:0] ENV_FLOOR = 24'd839;
  localparam logic [23:0] AMP_Q24 = 24'd13421773;
  localparam logic signed [AW-1:0] OSC_MAX = AW'(8388607);
  localparam logic signed [AW-1:0] OSC_MIN = -AW'(8388608);

  typedef enum logic [1:0] {
    REG_OSC_COEF,
    REG_START_SINE,
    REG_DECAY_COEF,
    REG_MAX_LEN
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic b_signed;
  } mul_req_t;

  // floor(p / 2^sh + 1/2)
  function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] p,
                                                       input int unsigned sh);
    logic signed [PW-1:0] half;
    half = PW'(1) <<< (sh - 1);
    return (p + half) >>> sh;
  endfunction

endpackage

// ===== hw/rtl/dskv_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on dskv_pkg for widths and the request struct
module dskv_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  dskv_pkg::mul_req_t                req,
  input  logic signed [dskv_pkg::AW-1:0]    a,
  input  logic        [dskv_pkg::BW-1:0]    b,
  output logic                              done,
  output logic signed [dskv_pkg::PW-1:0]    product
);

  localparam int AW = dskv_pkg::AW;
  localparam int BW = dskv_pkg::BW;
  localparam int CW = $clog2(BW);

  logic signed [AW-1:0] a_r;
  logic signed [AW:0]   hi;
  logic [BW-1:0]        lo;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 b_signed;
  logic signed [AW+1:0] sum;
  logic signed [AW+1:0] hi_ext;
  logic signed [AW+1:0] a_ext;

  assign hi_ext = (AW+2)'(hi);
  assign a_ext  = (AW+2)'(a_r);

  always_comb begin
    sum = hi_ext;
    if (lo[0]) begin
      // msb of a signed multiplier carries negative weight
      if (b_signed && (cnt == CW'(BW - 1))) begin
        sum = hi_ext - a_ext;
      end else begin
        sum = hi_ext + a_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        hi       <= '0;
        lo       <= b;
        a_r      <= a;
        b_signed <= req.b_signed;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        hi  <= sum[AW+1:1];
        lo  <= {sum[0], lo[BW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi, lo};

endmodule

// ===== hw/rtl/dskv_regs.sv =====
// configuration registers behind the apb-style port
// depends on dskv_pkg for register indexes and reset values
module dskv_regs #(
  parameter int COUNT_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dskv_pkg::ADDR_W-1:0]      paddr,
  input  logic [dskv_pkg::CFG_W-1:0]       pwdata,
  output logic [dskv_pkg::CFG_W-1:0]       prdata,
  output logic                             pready,
  output logic signed [23:0]               osc_coef,
  output logic [22:0]                      start_sine,
  output logic [23:0]                      decay_coef,
  output logic [COUNT_BITS-1:0]            max_len
);

  localparam int CFG_W = dskv_pkg::CFG_W;

  dskv_pkg::reg_idx_t idx;

  assign idx    = dskv_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_coef   <= dskv_pkg::OSC_COEF_RST;
      start_sine <= dskv_pkg::START_SINE_RST;
      decay_coef <= dskv_pkg::DECAY_COEF_RST;
      max_len    <= COUNT_BITS'(dskv_pkg::MAX_LEN_RST);
    end else if (psel && penable && pwrite) begin
      case (idx)
        dskv_pkg::REG_OSC_COEF:   osc_coef   <= pwdata[23:0];
        dskv_pkg::REG_START_SINE: start_sine <= pwdata[22:0];
        dskv_pkg::REG_DECAY_COEF: decay_coef <= pwdata[23:0];
        dskv_pkg::REG_MAX_LEN:    max_len    <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dskv_pkg::REG_OSC_COEF:   prdata = CFG_W'(osc_coef[23:0]);
      dskv_pkg::REG_START_SINE: prdata = CFG_W'(start_sine);
      dskv_pkg::REG_DECAY_COEF: prdata = CFG_W'(decay_coef);
      dskv_pkg::REG_MAX_LEN:    prdata = CFG_W'(max_len);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/decaying_sine_kick_voice_top.sv =====
// top level of the decaying sine kick voice: sequencer, voice state, stream ports
// depends on dskv_pkg, dskv_regs and dskv_mul
//
// one request on the input stream carries a stereo mix sample (tdata) and a
// trigger flag (tuser); one request on the output stream returns the mixed
// stereo sample (tdata) and a sounding flag (tuser). configuration goes
// through the apb-style port; the user writes it only while the block is idle,
// the block itself does not enforce this. a sample is taken only when the
// sequencer is idle; the result sits in an output register, so the next sample
// is taken while it waits. while the voice is idle a sample passes through the
// check and done states into the output register. a sounding sample runs four
// 24-step bit-serial multiplications (envelope decay, sine recurrence, envelope
// times sine, output gain) one after another on the one shared multiplier.
// reset returns the registers to their defaults, silences the voice and
// empties the output register. if the receiver stalls, a finished result
// is held and the sequencer waits before loading the next one.
module decaying_sine_kick_voice_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left_in, right_in, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // trigger
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // left_out, right_out, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // sounding
  output logic [0:0]                            m_axis_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dskv_pkg::ADDR_W-1:0]           paddr,
  input  logic [dskv_pkg::CFG_W-1:0]            pwdata,
  output logic [dskv_pkg::CFG_W-1:0]            prdata,
  output logic                                  pready
);

  localparam int DW   = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int AW   = dskv_pkg::AW;
  localparam int PW   = dskv_pkg::PW;
  localparam int SUMW = ((SAMPLE_BITS > AW) ? SAMPLE_BITS : AW) + 1;
  localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MENV,
    ST_MOSC,
    ST_MENVY,
    ST_MAMP,
    ST_DONE
  } state_t;

  state_t state;

  logic signed [23:0]           osc_coef;
  logic [22:0]                  start_sine;
  logic [23:0]                  decay_coef;
  logic [COUNT_BITS-1:0]        max_len;

  logic [COUNT_BITS-1:0]        sample_count;
  logic                         voice_active;
  logic [23:0]                  envelope;
  logic signed [23:0]           osc_last;
  logic signed [23:0]           osc_before_last;

  logic signed [SAMPLE_BITS-1:0] in_l;
  logic signed [SAMPLE_BITS-1:0] in_r;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic                          res_snd;
  logic signed [SAMPLE_BITS-1:0] out_l;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                          out_snd;
  logic                          out_valid;

  dskv_pkg::mul_req_t            mreq;
  logic signed [AW-1:0]          mul_a;
  logic [dskv_pkg::BW-1:0]       mul_b;
  logic                          mul_done;
  logic signed [PW-1:0]          product;

  logic signed [PW-1:0]          rnd23;
  logic signed [PW-1:0]          rnd22;
  logic signed [PW-1:0]          rnd24;
  logic [23:0]                   env_new;
  logic signed [AW-1:0]          y_diff;
  logic signed [23:0]            y_new;
  logic signed [SUMW-1:0]        sum_l;
  logic signed [SUMW-1:0]        sum_r;
  logic signed [SAMPLE_BITS-1:0] sat_l;
  logic signed [SAMPLE_BITS-1:0] sat_r;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [SUMW-1:0] s);
    logic signed [SUMW-1:0] c;
    c = s;
    if (s > SMAX) begin
      c = SMAX;
    end else if (s < SMIN) begin
      c = SMIN;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  dskv_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .osc_coef   (osc_coef),
    .start_sine (start_sine),
    .decay_coef (decay_coef),
    .max_len    (max_len)
  );

  dskv_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  assign rnd23 = dskv_pkg::round_shift(product, 23);
  assign rnd22 = dskv_pkg::round_shift(product, 22);
  assign rnd24 = dskv_pkg::round_shift(product, 24);

  assign env_new = (|rnd23[PW-1:24]) ? dskv_pkg::ENV_MAX : rnd23[23:0];
  assign y_diff  = $signed(rnd22[AW-1:0]) - AW'(osc_before_last);

  always_comb begin
    y_new = y_diff[23:0];
    if (y_diff > dskv_pkg::OSC_MAX) begin
      y_new = 24'sh7fffff;
    end else if (y_diff < dskv_pkg::OSC_MIN) begin
      y_new = 24'sh800000;
    end
  end

  assign sum_l = SUMW'(in_l) + SUMW'($signed(rnd24[AW-1:0]));
  assign sum_r = SUMW'(in_r) + SUMW'($signed(rnd24[AW-1:0]));
  assign sat_l = sat_out(sum_l);
  assign sat_r = sat_out(sum_r);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DW'({out_r, out_l});
  assign m_axis_tuser  = out_snd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      mreq         <= '0;
      sample_count <= '0;
      voice_active <= 1'b0;
      envelope     <= '0;
      osc_last     <= '0;
      osc_before_last <= '0;
    end else begin
      mreq.start <= 1'b0;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_l <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_r <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            if (s_axis_tuser[0]) begin
              sample_count    <= '0;
              voice_active    <= 1'b1;
              envelope        <= dskv_pkg::ENV_ONE;
              osc_last        <= '0;
              osc_before_last <= -$signed({1'b0, start_sine});
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!voice_active || (sample_count >= max_len)) begin
            voice_active <= 1'b0;
            res_l        <= in_l;
            res_r        <= in_r;
            res_snd      <= 1'b0;
            state        <= ST_DONE;
          end else begin
            mreq.start    <= 1'b1;
            mreq.b_signed <= 1'b0;
            mul_a         <= AW'($signed({1'b0, envelope}));
            mul_b         <= decay_coef;
            state         <= ST_MENV;
          end
        end
        ST_MENV: begin
          if (mul_done) begin
            envelope      <= env_new;
            mreq.start    <= 1'b1;
            mreq.b_signed <= 1'b1;
            mul_a         <= AW'(osc_last);
            mul_b         <= osc_coef;
            state         <= ST_MOSC;
          end
        end
        ST_MOSC: begin
          if (mul_done) begin
            osc_before_last <= osc_last;
            osc_last        <= y_new;
            mreq.start      <= 1'b1;
            mreq.b_signed   <= 1'b0;
            mul_a           <= AW'(y_new);
            mul_b           <= envelope;
            state           <= ST_MENVY;
          end
        end
        ST_MENVY: begin
          if (mul_done) begin
            mreq.start    <= 1'b1;
            mreq.b_signed <= 1'b0;
            mul_a         <= rnd22[AW-1:0];
            mul_b         <= dskv_pkg::AMP_Q24;
            state         <= ST_MAMP;
          end
        end
        ST_MAMP: begin
          if (mul_done) begin
            res_l   <= sat_l;
            res_r   <= sat_r;
            res_snd <= 1'b1;
            if (envelope < dskv_pkg::ENV_FLOOR) begin
              voice_active <= 1'b0;
            end else begin
              sample_count <= sample_count + 1'b1;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_l     <= res_l;
            out_r     <= res_r;
            out_snd   <= res_snd;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dskv_checker.sv =====
// port-level checks of the kick voice top level and the bind that attaches them
// depends on assert_macros.svh
`include "assert_macros.svh"

module dskv_port_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic [0:0]                         m_axis_tuser
);

  logic s_req;

  assign s_req = s_axis_tvalid && s_axis_tready;

  // output register empty after reset
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  // stalled result holds
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=>
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // one sample in flight at a time
  `ASSERT_CLK(a_one_in_flight, s_req |=> !s_axis_tready, "input taken while busy")

  // no result in the cycle right after a request taken while the output is empty
  `ASSERT_CLK(a_min_latency, s_req && !m_axis_tvalid |=> !m_axis_tvalid, "result too early")

  // a new result is loaded only from a busy sequencer
  `ASSERT_CLK(a_load_busy, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result from idle")

endmodule

bind decaying_sine_kick_voice_top dskv_port_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
